/* hw/rtl/hpfc_pkg.sv */
// Shared types and constants for the half precision format converter.
package hpfc_pkg;

	typedef enum logic [1:0] {
		KIND_H2S  = 2'd0,
		KIND_S2H  = 2'd1,
		KIND_B2H  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	// exponent bias difference between binary32 and binary16
	localparam logic [7:0] BIAS_DIFF      = 8'd112;
	// biased binary32 exponent of a subnormal half whose leading one is at bit 0
	localparam logic [7:0] SUB_EXP_BASE   = BIAS_DIFF - 8'd9;
	// narrowing: below this biased exponent the result flushes to zero
	localparam logic [7:0] UNDER_LIM      = BIAS_DIFF - 8'd10;
	// narrowing: at or above this biased exponent the result is infinity
	localparam logic [7:0] OVER_LIM       = BIAS_DIFF + 8'd31;
	// narrowing: subnormal shift is SUB_SHIFT_BASE minus the biased exponent
	localparam logic [7:0] SUB_SHIFT_BASE = BIAS_DIFF + 8'd14;

	localparam logic [14:0] HALF_INF_MAG  = 15'h7c00;
	localparam logic [7:0]  SINGLE_EXP_MAX = 8'hff;
	localparam logic [4:0]  HALF_EXP_MAX   = 5'h1f;

endpackage

/* hw/rtl/hpfc_widen.sv */
// Binary16 to binary32 widening logic with subnormal normalization.
module hpfc_widen (
	input  logic [15:0] half_bits,
	output logic [31:0] single_bits
);

	logic        sign;
	logic [4:0]  exp_h;
	logic [9:0]  frac_h;
	logic [3:0]  lead;
	logic [3:0]  norm_sh;
	logic [9:0]  norm_frac;
	logic [7:0]  sub_exp;

	assign sign   = half_bits[15];
	assign exp_h  = half_bits[14:10];
	assign frac_h = half_bits[9:0];

	// leading-one position of a subnormal fraction
	always_comb begin
		lead = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (frac_h[i]) begin
				lead = 4'(i);
			end
		end
	end

	assign norm_sh   = 4'd10 - lead;
	assign norm_frac = 10'(frac_h << norm_sh);
	assign sub_exp   = hpfc_pkg::SUB_EXP_BASE + {4'd0, lead};

	always_comb begin
		if (exp_h == 5'd0) begin
			if (frac_h == 10'd0) begin
				single_bits = {sign, 31'd0};
			end else begin
				single_bits = {sign, sub_exp, norm_frac, 13'd0};
			end
		end else if (exp_h == hpfc_pkg::HALF_EXP_MAX) begin
			single_bits = {sign, hpfc_pkg::SINGLE_EXP_MAX, frac_h, 13'd0};
		end else begin
			single_bits = {sign, hpfc_pkg::BIAS_DIFF + {3'd0, exp_h}, frac_h, 13'd0};
		end
	end

endmodule

/* hw/rtl/hpfc_narrow.sv */
// Binary32 to binary16 narrowing logic, round half away from zero.
module hpfc_narrow (
	input  logic [31:0] single_bits,
	output logic [15:0] half_bits
);

	logic        sign;
	logic [7:0]  exp_s;
	logic [22:0] frac_s;
	logic [23:0] mant;
	logic [4:0]  sh;
	logic [4:0]  sh_m1;
	logic [10:0] sub_shifted;
	logic        rnd_bit;
	logic [10:0] sub_mag;
	logic [4:0]  norm_exp;
	logic [14:0] norm_mag;

	assign sign   = single_bits[31];
	assign exp_s  = single_bits[30:23];
	assign frac_s = single_bits[22:0];
	assign mant   = {1'b1, frac_s};

	assign sh          = 5'(hpfc_pkg::SUB_SHIFT_BASE - exp_s);
	assign sh_m1       = sh - 5'd1;
	assign sub_shifted = 11'(mant >> sh);
	assign rnd_bit     = mant[sh_m1];
	assign sub_mag     = sub_shifted + {10'd0, rnd_bit};

	assign norm_exp = 5'(exp_s - hpfc_pkg::BIAS_DIFF);
	assign norm_mag = {norm_exp, frac_s[22:13]} + {14'd0, frac_s[12]};

	always_comb begin
		if (exp_s < hpfc_pkg::UNDER_LIM) begin
			half_bits = {sign, 15'd0};
		end else if (exp_s <= hpfc_pkg::BIAS_DIFF) begin
			half_bits = {sign, 4'd0, sub_mag};
		end else if (exp_s >= hpfc_pkg::OVER_LIM) begin
			half_bits = {sign, hpfc_pkg::HALF_INF_MAG};
		end else begin
			half_bits = {sign, norm_mag};
		end
	end

endmodule

/* hw/rtl/half_precision_format_converter_unit.sv */
// Top level of the half precision format converter: request and result registers.
// Converts one floating-point pattern per request: kind 0 widens FP16 to FP32, kind 1
// narrows FP32 to FP16, kind 2 narrows BF16 to FP16 (FP16 results in bits 15..0, upper
// bits zero), kind 3 gives zero. Narrowing rounds half away from zero, flushes values
// below the subnormal range to signed zero and turns overflow, infinity and NaN into
// signed infinity. A request is registered, converted by single-pass logic, and the
// result registered in a second register that drives res_valid; one request is taken
// every cycle while the result side is not stalled.
module half_precision_format_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] operand_bits,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] result_bits
);

	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [31:0] op_s1;
	logic        valid_s2;
	logic [31:0] result_s2;
	logic        adv_s2;
	logic        adv_s1;
	logic [31:0] widen_out;
	logic [31:0] narrow_in;
	logic [15:0] narrow_out;
	logic [31:0] conv;

	assign adv_s2    = !valid_s2 || !res_stall;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) begin
			kind_s1 <= kind;
			op_s1   <= operand_bits;
		end
	end

	hpfc_widen u_widen (
		.half_bits   (op_s1[15:0]),
		.single_bits (widen_out)
	);

	assign narrow_in = (kind_s1 == hpfc_pkg::KIND_B2H) ? {op_s1[15:0], 16'd0} : op_s1;

	hpfc_narrow u_narrow (
		.single_bits (narrow_in),
		.half_bits   (narrow_out)
	);

	always_comb begin
		case (kind_s1)
			hpfc_pkg::KIND_H2S: conv = widen_out;
			hpfc_pkg::KIND_S2H: conv = {16'd0, narrow_out};
			hpfc_pkg::KIND_B2H: conv = {16'd0, narrow_out};
			default:            conv = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= conv;
		end
	end

	assign res_valid   = valid_s2;
	assign result_bits = result_s2;

`ifndef ASSERT_OFF
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2 && res_stall))
		else $error("request stalled without a full pipeline");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(op_s1) && $stable(kind_s1)))
		else $error("held request lost or changed");

	a_half_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2 && kind_s1 != hpfc_pkg::KIND_H2S)
		|=> (result_bits[31:16] == 16'd0))
		else $error("narrowed result has upper bits set");

	a_unused_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2 && kind_s1 == hpfc_pkg::KIND_NONE) |=> (result_bits == 32'd0))
		else $error("unused kind gave nonzero result");
`endif

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the half precision format converter unit.
`timescale 1ns / 1ps

module testbench;

	localparam int IDLE_LIMIT = 200;
	localparam int RANDOM_ITEMS = 750;

	typedef struct {
		hpfc_pkg::kind_t k;
		logic [31:0]     operand;
		logic [31:0]     result;
	} conversion_t;

	class conversion_scoreboard;
		conversion_t pending_results[$];
		int          errors;

		function new();
			errors = 0;
		endfunction

		function logic [31:0] widen_fp16(logic [15:0] h);
			logic [31:0] sgn;
			logic [10:0] m;
			int          e;
			sgn = {h[15], 31'b0};
			m = {1'b0, h[9:0]};
			if (h[14:10] == 5'd0) begin
				if (m == 11'd0)
					return sgn;
				e = 1;
				while (m[10] == 1'b0) begin
					m = m << 1;
					e--;
				end
				return sgn | (32'((e + 112) & 255) << 23) | (32'(m[9:0]) << 13);
			end
			if (h[14:10] == 5'h1f)
				return sgn | 32'h7f80_0000 | (32'(h[9:0]) << 13);
			return sgn | ((32'(h[14:10]) + 32'd112) << 23) | (32'(h[9:0]) << 13);
		endfunction

		function logic [31:0] narrow_fp32(logic [31:0] b);
			logic [31:0] sgn;
			logic [31:0] frac;
			logic [31:0] hm;
			logic [31:0] half;
			int          ex;
			int          sh;
			sgn = {16'b0, b[31], 15'b0};
			ex = int'(b[30:23]) - 112;
			frac = {9'b0, b[22:0]};
			if (ex <= 0) begin
				if (ex < -10)
					return sgn;
				frac = frac | 32'h0080_0000;
				sh = 14 - ex;
				hm = frac >> sh;
				if (frac[sh - 1])
					hm = hm + 32'd1;
				return sgn | hm;
			end
			if (ex >= 31)
				return sgn | 32'h0000_7c00;
			half = sgn | (32'(ex) << 10) | (frac >> 13);
			if (frac[12])
				half = half + 32'd1;
			return half & 32'h0000_ffff;
		endfunction

		function logic [31:0] convert_pattern(hpfc_pkg::kind_t k, logic [31:0] op);
			case (k)
				hpfc_pkg::KIND_H2S: return widen_fp16(op[15:0]);
				hpfc_pkg::KIND_S2H: return narrow_fp32(op);
				hpfc_pkg::KIND_B2H: return narrow_fp32({op[15:0], 16'b0});
				default:            return 32'd0;
			endcase
		endfunction

		function void note_request(hpfc_pkg::kind_t k, logic [31:0] op);
			conversion_t c;
			c.k = k;
			c.operand = op;
			c.result = convert_pattern(k, op);
			pending_results.push_back(c);
		endfunction

		function void check_result(logic [31:0] r);
			conversion_t c;
			if (pending_results.size() == 0) begin
				$error("result_bits: unexpected result %h with nothing pending", r);
				errors++;
				return;
			end
			c = pending_results.pop_front();
			if (r !== c.result) begin
				$error("result_bits: expected %h, actual %h (kind %s, operand %h)",
					c.result, r, c.k.name(), c.operand);
				errors++;
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_stall;
	hpfc_pkg::kind_t kind = hpfc_pkg::KIND_H2S;
	logic [31:0]     operand_bits = 32'd0;
	logic            res_valid;
	logic            res_stall = 1'b0;
	logic [31:0]     result_bits;

	conversion_scoreboard board;
	bit tx_calm = 1'b0;
	int idle_cycles = 0;

	half_precision_format_converter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.kind         (kind),
		.operand_bits (operand_bits),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.result_bits  (result_bits)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_request(hpfc_pkg::kind_t k, logic [31:0] op);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		kind <= k;
		operand_bits <= op;
		do @(posedge clk); while (req_stall);
		board.note_request(k, op);
	endtask

	function automatic logic [31:0] make_operand(hpfc_pkg::kind_t k);
		logic [31:0] r;
		int          pick;
		r = $urandom();
		pick = $urandom_range(0, 7);
		case (k)
			hpfc_pkg::KIND_H2S: begin
				if (pick == 5) begin
					r[14:10] = 5'd0;
					if ($urandom_range(0, 3) == 0)
						r[9:0] = 10'd0;
				end else if (pick == 6) begin
					r[14:10] = 5'h1f;
				end
			end
			hpfc_pkg::KIND_S2H: begin
				if (pick >= 2 && pick <= 5) begin
					r[30:23] = 8'($urandom_range(100, 144));
				end else if (pick == 6) begin
					r[30:23] = 8'($urandom_range(101, 143));
					r[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0fff;
				end else if (pick == 7) begin
					r[30:23] = $urandom_range(0, 1) ? 8'h00 : 8'hff;
				end
			end
			hpfc_pkg::KIND_B2H: begin
				if (pick >= 2 && pick <= 6)
					r[14:7] = 8'($urandom_range(100, 144));
				else if (pick == 7)
					r[14:7] = $urandom_range(0, 1) ? 8'h00 : 8'hff;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic hpfc_pkg::kind_t pick_kind();
		int p;
		p = $urandom_range(0, 9);
		if (p <= 2)
			return hpfc_pkg::KIND_H2S;
		if (p <= 6)
			return hpfc_pkg::KIND_S2H;
		if (p <= 8)
			return hpfc_pkg::KIND_B2H;
		return hpfc_pkg::KIND_NONE;
	endfunction

	// result side: random stall ahead of every result, with calm stretches
	initial begin
		int hold;
		bit rx_calm;
		rx_calm = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_calm = !rx_calm;
			hold = rx_calm ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				@(negedge clk);
				res_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk);
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
			board.check_result(result_bits);
		end
	end

	initial begin
		hpfc_pkg::kind_t k;
		board = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// widening: zeros, subnormal range, normal limits, infinity, NaN, ignored upper half
		send_request(hpfc_pkg::KIND_H2S, 32'h0000_0000);
		send_request(hpfc_pkg::KIND_H2S, 32'h0000_8000);
		send_request(hpfc_pkg::KIND_H2S, 32'h0000_0001);
		send_request(hpfc_pkg::KIND_H2S, 32'h0000_03ff);
		send_request(hpfc_pkg::KIND_H2S, 32'h0000_0400);
		send_request(hpfc_pkg::KIND_H2S, 32'h0000_7bff);
		send_request(hpfc_pkg::KIND_H2S, 32'h0000_fc00);
		send_request(hpfc_pkg::KIND_H2S, 32'h0000_7e01);
		send_request(hpfc_pkg::KIND_H2S, 32'hffff_3c00);
		// narrowing: underflow edge, subnormal carry, overflow, specials, tie; then BF16 inputs and the unused kind
		send_request(hpfc_pkg::KIND_S2H, 32'h8000_0000);
		send_request(hpfc_pkg::KIND_S2H, 32'h0000_0001);
		send_request(hpfc_pkg::KIND_S2H, 32'h3300_0000);
		send_request(hpfc_pkg::KIND_S2H, 32'h32ff_ffff);
		send_request(hpfc_pkg::KIND_S2H, 32'h387f_e000);
		send_request(hpfc_pkg::KIND_S2H, 32'h477f_f000);
		send_request(hpfc_pkg::KIND_S2H, 32'hc77f_efff);
		send_request(hpfc_pkg::KIND_S2H, 32'h4780_0000);
		send_request(hpfc_pkg::KIND_S2H, 32'hff80_0000);
		send_request(hpfc_pkg::KIND_S2H, 32'h7fc0_0001);
		send_request(hpfc_pkg::KIND_S2H, 32'h3f80_1000);
		send_request(hpfc_pkg::KIND_B2H, 32'habcd_3f80);
		send_request(hpfc_pkg::KIND_B2H, 32'h0000_ffc1);
		send_request(hpfc_pkg::KIND_B2H, 32'h0000_477f);
		send_request(hpfc_pkg::KIND_NONE, 32'hffff_ffff);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			k = pick_kind();
			send_request(k, make_operand(k));
		end
		@(negedge clk);
		req_valid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
